// ----- hdl/nsc_pkg.sv -----
// Package for the NMEA sentence checker: item and result types, character
// constants, register indexes and reset values. No dependencies.
package nsc_pkg;

    localparam int DEF_MAX_LEN     = 128;
    localparam int DEF_QUEUE_DEPTH = 2;

    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 2;
    localparam int FIELD_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_GLL_IDX = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GGA_IDX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RMC_IDX = 2'd2;

    localparam logic [CFG_W-1:0] GLL_COUNT_RST = 6'd5;
    localparam logic [CFG_W-1:0] GGA_COUNT_RST = 6'd14;
    localparam logic [CFG_W-1:0] RMC_COUNT_RST = 6'd11;

    localparam logic [FIELD_W-1:0] FIELD_MAX = 6'd63;

    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_P      = 8'h50;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] CHAR_COMMA  = 8'h2C;
    localparam logic [7:0] CHAR_0      = 8'h30;
    localparam logic [7:0] CHAR_9      = 8'h39;
    localparam logic [7:0] CHAR_UA     = 8'h41;
    localparam logic [7:0] CHAR_UF     = 8'h46;
    localparam logic [7:0] CHAR_UZ     = 8'h5A;
    localparam logic [7:0] CHAR_LA     = 8'h61;
    localparam logic [7:0] CHAR_LF     = 8'h66;

    // sentence tags, first letter in the top byte
    localparam logic [23:0] TAG_GLL = 24'h474C4C;
    localparam logic [23:0] TAG_GGA = 24'h474741;
    localparam logic [23:0] TAG_RMC = 24'h524D43;

    // positions within the line
    localparam int POS_LETTERS = 3;
    localparam int POS_COMMA   = 6;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_GLL  = 2'd1,
        FMT_GGA  = 2'd2,
        FMT_RMC  = 2'd3
    } fmt_t;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       line_end;
        logic       is_hex;
        logic [3:0] hex_nib;
        logic       is_upper;
        logic       is_dollar;
        logic       is_star;
        logic       is_comma;
    } nsc_item_t;

    typedef struct packed {
        logic               structure_ok;
        logic               checksum_ok;
        logic [7:0]         computed_sum;
        logic [7:0]         received_sum;
        fmt_t               format_code;
        logic [FIELD_W-1:0] field_count;
        logic               fields_ok;
        logic               accepted;
    } nsc_result_t;

endpackage

// ----- hdl/nsc_front.sv -----
// Front end of the NMEA sentence checker: takes requests and classifies each
// character before it enters the queue. Depends on nsc_pkg.
module nsc_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           char_byte,
    input  logic                 line_end,
    input  logic                 q_full,
    output logic                 q_push,
    output nsc_pkg::nsc_item_t   q_item
);
    import nsc_pkg::*;

    logic is_digit;
    logic is_upper_hex;
    logic is_lower_hex;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    assign is_digit     = (char_byte >= CHAR_0)  && (char_byte <= CHAR_9);
    assign is_upper_hex = (char_byte >= CHAR_UA) && (char_byte <= CHAR_UF);
    assign is_lower_hex = (char_byte >= CHAR_LA) && (char_byte <= CHAR_LF);

    always_comb
    begin
        q_item.char_byte = char_byte;
        q_item.line_end  = line_end;
        q_item.is_hex    = is_digit || is_upper_hex || is_lower_hex;
        // letters A..F and a..f both have low nibble 1..6: add 9 for 10..15
        q_item.hex_nib   = is_digit ? char_byte[3:0] : char_byte[3:0] + 4'd9;
        q_item.is_upper  = (char_byte >= CHAR_UA) && (char_byte <= CHAR_UZ);
        q_item.is_dollar = (char_byte == CHAR_DOLLAR);
        q_item.is_star   = (char_byte == CHAR_STAR);
        q_item.is_comma  = (char_byte == CHAR_COMMA);
    end

endmodule

// ----- hdl/nsc_queue.sv -----
// Short queue between the front end and the line checker of the NMEA
// sentence checker. Depends on nsc_pkg for the item type.
module nsc_queue #(
    parameter int DEPTH = nsc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  nsc_pkg::nsc_item_t   push_item,
    input  logic                 pop,
    output nsc_pkg::nsc_item_t   head_item,
    output logic                 full,
    output logic                 not_empty
);
    import nsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    nsc_item_t        mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count above depth");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !not_empty |-> !pop)
        else $error("pop from empty queue");

endmodule

// ----- hdl/nsc_back.sv -----
// Line checker of the NMEA sentence checker: walks the classified characters,
// keeps the per-line state and the field count registers, and holds the
// verdict in an output register. Depends on nsc_pkg.
module nsc_back #(
    parameter int MAX_LEN = nsc_pkg::DEF_MAX_LEN
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nsc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              q_not_empty,
    input  nsc_pkg::nsc_item_t                q_item,
    output logic                              q_pop,
    input  logic                              out_ready,
    output logic                              out_valid,
    output nsc_pkg::nsc_result_t              res
);
    import nsc_pkg::*;

    localparam int POS_W = $clog2(MAX_LEN + 1);
    localparam logic [POS_W-1:0] MAX_POS  = POS_W'(MAX_LEN);
    localparam logic [POS_W-1:0] POS_L0   = POS_W'(POS_LETTERS);
    localparam logic [POS_W-1:0] POS_L1   = POS_W'(POS_LETTERS + 1);
    localparam logic [POS_W-1:0] POS_L2   = POS_W'(POS_LETTERS + 2);
    localparam logic [POS_W-1:0] POS_CMA  = POS_W'(POS_COMMA);
    localparam logic [POS_W-1:0] POS_P1   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_P2   = POS_W'(2);

    logic [CFG_W-1:0]   gll_cnt_reg, gga_cnt_reg, rmc_cnt_reg;

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               flag_reg, flag_next;
    logic [7:0]         xor_reg, xor_next;
    logic               star_reg, star_next;
    logic [1:0]         digits_reg, digits_next;
    logic [7:0]         hex_reg, hex_next;
    logic [23:0]        tag_reg, tag_next;
    logic [FIELD_W-1:0] field_reg, field_next;

    logic               out_valid_reg, out_valid_next;
    nsc_result_t        res_reg, res_next;

    logic               pop_end;
    logic               bump;
    logic               do_xor;
    logic               sok;
    logic               cok;
    fmt_t               fmt;
    logic [CFG_W-1:0]   expect_cnt;

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // a line end waits until the output register is free
    assign q_pop   = q_not_empty && (!q_item.line_end || !out_valid_reg || out_ready);
    assign pop_end = q_pop && q_item.line_end;

    always_comb
    begin
        sok = flag_reg && star_reg && (digits_reg == 2'd2);
        cok = sok && (xor_reg == hex_reg);
        fmt = FMT_NONE;
        expect_cnt = '0;
        if (tag_reg == TAG_GLL)
        begin
            fmt = FMT_GLL;
            expect_cnt = gll_cnt_reg;
        end
        else if (tag_reg == TAG_GGA)
        begin
            fmt = FMT_GGA;
            expect_cnt = gga_cnt_reg;
        end
        else if (tag_reg == TAG_RMC)
        begin
            fmt = FMT_RMC;
            expect_cnt = rmc_cnt_reg;
        end
        res_next.structure_ok = sok;
        res_next.checksum_ok  = cok;
        res_next.computed_sum = xor_reg;
        res_next.received_sum = hex_reg;
        res_next.format_code  = fmt;
        res_next.field_count  = field_reg;
        res_next.fields_ok    = (fmt != FMT_NONE) && (field_reg == expect_cnt);
        res_next.accepted     = sok && cok && res_next.fields_ok;
    end

    always_comb
    begin
        pos_next    = pos_reg;
        flag_next   = flag_reg;
        xor_next    = xor_reg;
        star_next   = star_reg;
        digits_next = digits_reg;
        hex_next    = hex_reg;
        tag_next    = tag_reg;
        field_next  = field_reg;
        bump        = 1'b0;
        do_xor      = 1'b0;

        if (pop_end)
        begin
            pos_next    = '0;
            flag_next   = 1'b1;
            xor_next    = '0;
            star_next   = 1'b0;
            digits_next = '0;
            hex_next    = '0;
            tag_next    = '0;
            field_next  = '0;
        end
        else if (q_pop)
        begin
            if (pos_reg >= MAX_POS)
            begin
                // overlong line: mark and drop
                flag_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
                if (pos_reg < POS_L0)
                begin
                    if (pos_reg == '0 && !q_item.is_dollar)
                        flag_next = 1'b0;
                    if (pos_reg == POS_P1 && q_item.char_byte != CHAR_G)
                        flag_next = 1'b0;
                    if (pos_reg == POS_P2 && q_item.char_byte != CHAR_P)
                        flag_next = 1'b0;
                    do_xor = (pos_reg != '0);
                end
                else if (pos_reg < POS_CMA)
                begin
                    if (!q_item.is_upper)
                        flag_next = 1'b0;
                    if (pos_reg == POS_L0)
                        tag_next[23:16] = q_item.char_byte;
                    if (pos_reg == POS_L1)
                        tag_next[15:8] = q_item.char_byte;
                    if (pos_reg == POS_L2)
                        tag_next[7:0] = q_item.char_byte;
                    do_xor = 1'b1;
                end
                else if (pos_reg == POS_CMA)
                begin
                    if (!q_item.is_comma)
                        flag_next = 1'b0;
                    do_xor = 1'b1;
                end
                else
                begin
                    if (q_item.is_dollar)
                        flag_next = 1'b0;
                    if (star_reg)
                    begin
                        if (!q_item.is_hex || digits_reg == 2'd2)
                        begin
                            flag_next = 1'b0;
                        end
                        else
                        begin
                            hex_next    = {hex_reg[3:0], q_item.hex_nib};
                            digits_next = digits_reg + 1'b1;
                        end
                    end
                    else if (q_item.is_star)
                    begin
                        star_next = 1'b1;
                        bump      = 1'b1;
                    end
                    else
                    begin
                        bump   = q_item.is_comma;
                        do_xor = 1'b1;
                    end
                end
            end
            if (do_xor)
                xor_next = xor_reg ^ q_item.char_byte;
            if (bump && field_reg != FIELD_MAX)
                field_next = field_reg + 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_end)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gll_cnt_reg   <= GLL_COUNT_RST;
            gga_cnt_reg   <= GGA_COUNT_RST;
            rmc_cnt_reg   <= RMC_COUNT_RST;
            pos_reg       <= '0;
            flag_reg      <= 1'b1;
            xor_reg       <= '0;
            star_reg      <= 1'b0;
            digits_reg    <= '0;
            hex_reg       <= '0;
            tag_reg       <= '0;
            field_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_GLL_IDX: gll_cnt_reg <= cfg_data;
                    CFG_GGA_IDX: gga_cnt_reg <= cfg_data;
                    CFG_RMC_IDX: rmc_cnt_reg <= cfg_data;
                    default: ;
                endcase
            end
            pos_reg       <= pos_next;
            flag_reg      <= flag_next;
            xor_reg       <= xor_next;
            star_reg      <= star_next;
            digits_reg    <= digits_next;
            hex_reg       <= hex_next;
            tag_reg       <= tag_next;
            field_reg     <= field_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_end)
            res_reg <= res_next;
    end

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        pop_end |=> (pos_reg == '0 && flag_reg && !star_reg && field_reg == '0))
        else $error("line state not cleared after line end");

    a_accept_implies: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!res_reg.accepted ||
            (res_reg.structure_ok && res_reg.checksum_ok && res_reg.fields_ok)))
        else $error("accepted without all checks passing");

    a_hex_after_star: assert property (@(posedge clk) disable iff (!rst_n)
        !star_reg |-> (digits_reg == '0 && hex_reg == '0))
        else $error("checksum digits taken before star");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= MAX_POS)
        else $error("character position past line limit");

endmodule

// ----- hdl/nmea_sentence_checker.sv -----
// Top level of the NMEA sentence checker: front end, queue and line checker.
// Depends on nsc_pkg, nsc_front, nsc_queue and nsc_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one request per character of a line,
//   char_byte holding the character; a request with line_end high closes the
//   line (char_byte ignored) and yields exactly one verdict.
//   Output channel (out_valid/out_ready): one verdict per line with the
//   structure, checksum and field count results.
//   Configuration: cfg_we writes cfg_data into register cfg_index (0 GLL,
//   1 GGA, 2 RMC expected field counts); write only while the block is idle.
// Timing:
//   One request per cycle sustained while the queue has room. A request is
//   queued when accepted and consumed in order by the line checker; the
//   verdict is registered onto out_valid when the line end is consumed.
//   When out_ready is low a finished verdict is held in the output register;
//   characters keep flowing, and only the next line end waits, so in_ready
//   drops once the queue (QUEUE_DEPTH entries) fills behind it.
// Reset:
//   Clears the line state and the queue and loads the field counts 5, 14, 11.
module nmea_sentence_checker #(
    parameter int MAX_LEN     = nsc_pkg::DEF_MAX_LEN,
    parameter int QUEUE_DEPTH = nsc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [nsc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nsc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        char_byte,
    input  logic                              line_end,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              structure_ok,
    output logic                              checksum_ok,
    output logic [7:0]                        computed_sum,
    output logic [7:0]                        received_sum,
    output logic [1:0]                        format_code,
    output logic [nsc_pkg::FIELD_W-1:0]       field_count,
    output logic                              fields_ok,
    output logic                              accepted
);
    import nsc_pkg::*;

    nsc_item_t   push_item;
    nsc_item_t   head_item;
    nsc_result_t res;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_not_empty;

    nsc_front u_front (
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .line_end  (line_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    nsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .pop       (q_pop),
        .head_item (head_item),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    nsc_back #(
        .MAX_LEN (MAX_LEN)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .q_not_empty (q_not_empty),
        .q_item      (head_item),
        .q_pop       (q_pop),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .res         (res)
    );

    assign structure_ok = res.structure_ok;
    assign checksum_ok  = res.checksum_ok;
    assign computed_sum = res.computed_sum;
    assign received_sum = res.received_sum;
    assign format_code  = res.format_code;
    assign field_count  = res.field_count;
    assign fields_ok    = res.fields_ok;
    assign accepted     = res.accepted;

endmodule
